FILE: design/etm_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// Euler TRS matrix builder. No dependencies.
`default_nettype none
package etm_pkg;

  localparam int SCALE_W = 24;
  localparam int SHIFT_W = 32;
  localparam int OUT_W   = 32;
  localparam int MAG_W   = 24;

  // CORDIC sine/cosine pipeline
  localparam int CW               = 18;
  localparam int CORDIC_STEPS     = 15;
  localparam int CORDIC_PER_STAGE = 3;
  localparam int CORDIC_STAGES    = (CORDIC_STEPS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;
  localparam int CORDIC_LAT       = CORDIC_STAGES + 2;

  typedef logic signed [CW-1:0] cord_t;
  typedef logic signed [15:0]   trig_t;

  localparam cord_t X_INIT    = 18'sd19898;
  localparam cord_t TRIG_MAX  = 18'sd32767;
  localparam cord_t TRIG_MIN  = -18'sd32767;

  localparam cord_t ATAN_TAB [0:CORDIC_STEPS-1] = '{
    18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
    18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1
  };

  // Rotation entries, Q30
  localparam int MAT_LAT = 3;
  typedef logic signed [32:0] r30_t;

  // Reciprocal divider
  localparam int DIV_BITS      = 31;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = (DIV_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int DIV_LAT       = DIV_STAGES + 1;

  localparam logic signed [OUT_W-1:0] POS_MAX = 32'sh7fffffff;

  typedef struct packed {
    logic signed [OUT_W-1:0] inv;
    logic                    sat;
  } recip_t;

  localparam int PROD_LAT = 2;

  typedef enum logic [1:0] {
    COL_0     = 2'd0,
    COL_1     = 2'd1,
    COL_2     = 2'd2,
    COL_SHIFT = 2'd3
  } col_t;

endpackage
`default_nettype wire

FILE: design/etm_delay.sv
// Enabled register delay line for payload alignment.
// Depends on nothing.
`default_nettype none
module etm_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] tap_r [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[D-1];
endmodule
`default_nettype wire

FILE: design/etm_cordic.sv
// Pipelined rotation-mode CORDIC: binary angle to Q1.15 cosine and sine.
// Depends on etm_pkg.
`default_nettype none
module etm_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output etm_pkg::trig_t             cos_o,
  output etm_pkg::trig_t             sin_o
);
  import etm_pkg::*;

  logic [15:0] phase;
  logic [15:0] phase_off;
  logic [1:0]  quad;
  logic [15:0] resid;

  if (ANGLE_BITS >= 16) begin : g_hi
    assign phase = angle[ANGLE_BITS-1 -: 16];
  end else begin : g_lo
    assign phase = {angle, {(16-ANGLE_BITS){1'b0}}};
  end

  assign phase_off = phase + 16'd8192;
  assign quad      = phase_off[15:14];
  assign resid     = phase - {quad, 14'd0};

  cord_t      x_r [0:CORDIC_STAGES];
  cord_t      y_r [0:CORDIC_STAGES];
  cord_t      z_r [0:CORDIC_STAGES];
  logic [1:0] q_r [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= X_INIT;
      y_r[0] <= '0;
      z_r[0] <= CW'($signed(resid));
      q_r[0] <= quad;
    end
  end

  for (genvar s = 1; s <= CORDIC_STAGES; s++) begin : g_stage
    cord_t x_nxt, y_nxt, z_nxt;
    always_comb begin
      cord_t dx, dy;
      x_nxt = x_r[s-1];
      y_nxt = y_r[s-1];
      z_nxt = z_r[s-1];
      for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
        if ((s-1)*CORDIC_PER_STAGE + k < CORDIC_STEPS) begin
          dx = y_nxt >>> ((s-1)*CORDIC_PER_STAGE + k);
          dy = x_nxt >>> ((s-1)*CORDIC_PER_STAGE + k);
          if (!z_nxt[CW-1]) begin
            x_nxt = x_nxt - dx;
            y_nxt = y_nxt + dy;
            z_nxt = z_nxt - ATAN_TAB[(s-1)*CORDIC_PER_STAGE + k];
          end else begin
            x_nxt = x_nxt + dx;
            y_nxt = y_nxt - dy;
            z_nxt = z_nxt + ATAN_TAB[(s-1)*CORDIC_PER_STAGE + k];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s] <= x_nxt;
        y_r[s] <= y_nxt;
        z_r[s] <= z_nxt;
        q_r[s] <= q_r[s-1];
      end
    end
  end

  trig_t cr, sr, cos_nxt, sin_nxt, cos_r, sin_r;

  always_comb begin
    cord_t xf, yf;
    xf = x_r[CORDIC_STAGES];
    yf = y_r[CORDIC_STAGES];
    if (xf > TRIG_MAX)      cr = TRIG_MAX[15:0];
    else if (xf < TRIG_MIN) cr = TRIG_MIN[15:0];
    else                    cr = xf[15:0];
    if (yf > TRIG_MAX)      sr = TRIG_MAX[15:0];
    else if (yf < TRIG_MIN) sr = TRIG_MIN[15:0];
    else                    sr = yf[15:0];
    unique case (q_r[CORDIC_STAGES])
      2'd0: begin cos_nxt = cr;  sin_nxt = sr;  end
      2'd1: begin cos_nxt = -sr; sin_nxt = cr;  end
      2'd2: begin cos_nxt = -cr; sin_nxt = -sr; end
      2'd3: begin cos_nxt = sr;  sin_nxt = -cr; end
      default: begin cos_nxt = cr; sin_nxt = sr; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;
endmodule
`default_nettype wire

FILE: design/etm_recip.sv
// Pipelined restoring divider: rounded signed reciprocal of one scale
// factor with overflow clamp. Depends on etm_pkg.
`default_nettype none
module etm_recip #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [etm_pkg::SCALE_W-1:0]  scale,
  output etm_pkg::recip_t                          res
);
  import etm_pkg::*;

  localparam int NW  = (2*FRACTION_BITS + 1 > DIV_BITS + 1) ? 2*FRACTION_BITS + 1 : DIV_BITS + 1;
  localparam int HW  = NW - DIV_BITS;
  localparam int CPW = (HW > MAG_W) ? HW : MAG_W;

  logic [MAG_W-1:0] mag_c;
  logic [NW-1:0]    num_c;
  logic [HW-1:0]    hi_c;
  logic             ovf_c;
  logic             zero_c;

  assign mag_c  = scale[SCALE_W-1] ? MAG_W'(-scale) : MAG_W'(scale);
  assign num_c  = (NW'(1) << (2*FRACTION_BITS)) + NW'(mag_c >> 1);
  assign hi_c   = num_c[NW-1:DIV_BITS];
  assign ovf_c  = CPW'(hi_c) >= CPW'(mag_c);
  assign zero_c = (mag_c == '0);

  logic [MAG_W-1:0]    rem_r  [0:DIV_STAGES];
  logic [DIV_BITS-1:0] quo_r  [0:DIV_STAGES];
  logic [DIV_BITS-1:0] low_r  [0:DIV_STAGES];
  logic [MAG_W-1:0]    mag_r  [0:DIV_STAGES];
  logic                neg_r  [0:DIV_STAGES];
  logic                sat_r  [0:DIV_STAGES];
  logic                zero_r [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= MAG_W'(hi_c);
      quo_r[0]  <= '0;
      low_r[0]  <= num_c[DIV_BITS-1:0];
      mag_r[0]  <= mag_c;
      neg_r[0]  <= scale[SCALE_W-1];
      sat_r[0]  <= zero_c | ovf_c;
      zero_r[0] <= zero_c;
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    logic [MAG_W-1:0]    rem_nxt;
    logic [DIV_BITS-1:0] quo_nxt;
    always_comb begin
      logic [MAG_W:0] trial;
      rem_nxt = rem_r[s-1];
      quo_nxt = quo_r[s-1];
      for (int k = 0; k < DIV_PER_STAGE; k++) begin
        if ((s-1)*DIV_PER_STAGE + k < DIV_BITS) begin
          trial = {rem_nxt, low_r[s-1][DIV_BITS-1-((s-1)*DIV_PER_STAGE + k)]};
          if (trial >= {1'b0, mag_r[s-1]}) begin
            rem_nxt = MAG_W'(trial - {1'b0, mag_r[s-1]});
            quo_nxt[DIV_BITS-1-((s-1)*DIV_PER_STAGE + k)] = 1'b1;
          end else begin
            rem_nxt = trial[MAG_W-1:0];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
        low_r[s]  <= low_r[s-1];
        mag_r[s]  <= mag_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        sat_r[s]  <= sat_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end
    end
  end

  logic signed [OUT_W-1:0] quo_s;
  assign quo_s = {1'b0, quo_r[DIV_STAGES]};

  always_comb begin
    res.sat = sat_r[DIV_STAGES];
    if (zero_r[DIV_STAGES])     res.inv = POS_MAX;
    else if (sat_r[DIV_STAGES]) res.inv = neg_r[DIV_STAGES] ? -POS_MAX : POS_MAX;
    else                        res.inv = neg_r[DIV_STAGES] ? -quo_s : quo_s;
  end
endmodule
`default_nettype wire

FILE: design/etm_rotation.sv
// Y-X-Z rotation matrix from six sines/cosines, three register stages,
// entries rounded to Q30. Depends on etm_pkg.
`default_nettype none
module etm_rotation (
  input  wire logic           clk,
  input  wire logic           en,
  input  etm_pkg::trig_t      cx,
  input  etm_pkg::trig_t      sx,
  input  etm_pkg::trig_t      cy,
  input  etm_pkg::trig_t      sy,
  input  etm_pkg::trig_t      cz,
  input  etm_pkg::trig_t      sz,
  output etm_pkg::r30_t       r30_o [9]
);
  import etm_pkg::*;

  // pair products
  logic signed [31:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r, p8_r, p9_r, p10_r;
  trig_t              sx1_r, sz1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= cy * cz;
      p2_r  <= sy * sx;
      p3_r  <= cx * sz;
      p4_r  <= cy * sx;
      p5_r  <= cz * sy;
      p6_r  <= cy * sz;
      p7_r  <= cx * cz;
      p8_r  <= sy * sz;
      p9_r  <= cx * sy;
      p10_r <= cy * cx;
      sx1_r <= sx;
      sz1_r <= sz;
    end
  end

  // triple products, pass the rest along
  logic signed [47:0] t1_r, t2_r, t3_r, t4_r;
  logic signed [31:0] q1_r, q3_r, q5_r, q6_r, q7_r, q8_r, q9_r, q10_r;
  trig_t              sx2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= p2_r * sz1_r;
      t2_r  <= p4_r * sz1_r;
      t3_r  <= p5_r * sx1_r;
      t4_r  <= p1_r * sx1_r;
      q1_r  <= p1_r;
      q3_r  <= p3_r;
      q5_r  <= p5_r;
      q6_r  <= p6_r;
      q7_r  <= p7_r;
      q8_r  <= p8_r;
      q9_r  <= p9_r;
      q10_r <= p10_r;
      sx2_r <= sx1_r;
    end
  end

  logic signed [47:0] m [9];
  r30_t               r30_nxt [9];
  r30_t               r30_r [9];

  always_comb begin
    logic signed [47:0] rounded;
    m[0] = (48'(q1_r) <<< 15) + t1_r;
    m[1] = 48'(q3_r) <<< 15;
    m[2] = t2_r - (48'(q5_r) <<< 15);
    m[3] = t3_r - (48'(q6_r) <<< 15);
    m[4] = 48'(q7_r) <<< 15;
    m[5] = t4_r + (48'(q8_r) <<< 15);
    m[6] = 48'(q9_r) <<< 15;
    m[7] = -(48'(sx2_r) <<< 30);
    m[8] = 48'(q10_r) <<< 15;
    for (int i = 0; i < 9; i++) begin
      rounded    = m[i] + 48'sd16384;
      r30_nxt[i] = rounded[47:15];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) r30_r[i] <= r30_nxt[i];
    end
  end

  assign r30_o = r30_r;
endmodule
`default_nettype wire

FILE: design/etm_scale_mult.sv
// Scale and reciprocal-scale products of the rotation entries, rounded
// and saturated to Q16.16 over two stages. Depends on etm_pkg.
`default_nettype none
module etm_scale_mult (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [etm_pkg::SCALE_W-1:0] sc    [3],
  input  wire logic signed [etm_pkg::OUT_W-1:0]   inv   [3],
  input  etm_pkg::r30_t                           r30   [9],
  output logic signed [etm_pkg::OUT_W-1:0]        model [9],
  output logic signed [etm_pkg::OUT_W-1:0]        normal[9]
);
  import etm_pkg::*;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh007fffffff)      sat32 = POS_MAX;
    else if (v < -40'sh0080000000) sat32 = -POS_MAX - 32'sd1;
    else                          sat32 = v[OUT_W-1:0];
  endfunction

  logic signed [56:0] mp_r [9];
  logic signed [64:0] np_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        mp_r[i] <= sc[i/3] * r30[i];
        np_r[i] <= inv[i/3] * r30[i];
      end
    end
  end

  logic signed [OUT_W-1:0] model_r [9];
  logic signed [OUT_W-1:0] normal_r[9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        model_r[i]  <= sat32(40'($signed(mp_r[i][56:30]
                       + 27'($signed({1'b0, mp_r[i][29]})))));
        normal_r[i] <= sat32(40'($signed(np_r[i][64:30]
                       + 35'($signed({1'b0, np_r[i][29]})))));
      end
    end
  end

  assign model  = model_r;
  assign normal = normal_r;
endmodule
`default_nettype wire

FILE: design/euler_trs_matrix_builder_top.sv
// Euler-angle TRS builder: model matrix and normal matrix columns.
// A request passes the CORDIC, rotation and scale-product stages into the output buffer.
// The pipeline holds while the output buffer, which issues the four columns of a
// transform one per cycle unless out_stall is high, still has columns to issue.
// Reset: synchronous, active low; clears the stage valid bits and the buffer's full flag and column.
`default_nettype none
module euler_trs_matrix_builder_top #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ANGLE_BITS-1:0]              in_angle_x,
  input  wire logic [ANGLE_BITS-1:0]              in_angle_y,
  input  wire logic [ANGLE_BITS-1:0]              in_angle_z,
  input  wire logic signed [etm_pkg::SCALE_W-1:0] in_scale_x,
  input  wire logic signed [etm_pkg::SCALE_W-1:0] in_scale_y,
  input  wire logic signed [etm_pkg::SCALE_W-1:0] in_scale_z,
  input  wire logic signed [etm_pkg::SHIFT_W-1:0] in_shift_x,
  input  wire logic signed [etm_pkg::SHIFT_W-1:0] in_shift_y,
  input  wire logic signed [etm_pkg::SHIFT_W-1:0] in_shift_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_column_index,
  output logic signed [etm_pkg::OUT_W-1:0]        out_model_row0,
  output logic signed [etm_pkg::OUT_W-1:0]        out_model_row1,
  output logic signed [etm_pkg::OUT_W-1:0]        out_model_row2,
  output logic signed [etm_pkg::OUT_W-1:0]        out_normal_row0,
  output logic signed [etm_pkg::OUT_W-1:0]        out_normal_row1,
  output logic signed [etm_pkg::OUT_W-1:0]        out_normal_row2,
  output logic                                    out_reciprocal_saturated,
  output logic                                    out_last_column
);
  import etm_pkg::*;

  // Pipeline depth up to the output buffer.
  localparam int ROT_LAT = CORDIC_LAT + MAT_LAT;
  localparam int TOTAL   = ROT_LAT + PROD_LAT;

  // Whole pipeline advances together; hold everything while the buffer
  // still has columns to issue.
  logic en;
  logic buf_full_r;
  col_t col_r;

  assign en       = !buf_full_r || (col_r == COL_SHIFT && !out_stall);
  assign in_stall = !en;

  logic v_r [0:TOTAL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < TOTAL; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Sine and cosine of the three angles.
  trig_t cx, sx, cy, sy, cz, sz;

  etm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_x (
    .clk(clk), .en(en), .angle(in_angle_x), .cos_o(cx), .sin_o(sx));
  etm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_y (
    .clk(clk), .en(en), .angle(in_angle_y), .cos_o(cy), .sin_o(sy));
  etm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_z (
    .clk(clk), .en(en), .angle(in_angle_z), .cos_o(cz), .sin_o(sz));

  r30_t r30 [9];

  etm_rotation u_rotation (
    .clk(clk), .en(en),
    .cx(cx), .sx(sx), .cy(cy), .sy(sy), .cz(cz), .sz(sz),
    .r30_o(r30));

  // Reciprocal scales, run alongside the CORDIC.
  recip_t rc_x, rc_y, rc_z;

  etm_recip #(.FRACTION_BITS(FRACTION_BITS)) u_recip_x (
    .clk(clk), .en(en), .scale(in_scale_x), .res(rc_x));
  etm_recip #(.FRACTION_BITS(FRACTION_BITS)) u_recip_y (
    .clk(clk), .en(en), .scale(in_scale_y), .res(rc_y));
  etm_recip #(.FRACTION_BITS(FRACTION_BITS)) u_recip_z (
    .clk(clk), .en(en), .scale(in_scale_z), .res(rc_z));

  // Align the side payloads with the rotation entries and the scale products.
  logic [3*SCALE_W-1:0]       sc_dly;
  logic [3*$bits(recip_t)-1:0] rc_dly;
  logic [2:0]                 sat_dly;
  logic [3*SHIFT_W-1:0]       shift_dly;
  recip_t                     rc_a [3];

  etm_delay #(.W(3*SCALE_W), .D(ROT_LAT)) u_dly_scale (
    .clk(clk), .en(en), .d({in_scale_z, in_scale_y, in_scale_x}), .q(sc_dly));
  etm_delay #(.W(3*$bits(recip_t)), .D(ROT_LAT - DIV_LAT)) u_dly_recip (
    .clk(clk), .en(en), .d({rc_z, rc_y, rc_x}), .q(rc_dly));
  etm_delay #(.W(3), .D(PROD_LAT)) u_dly_sat (
    .clk(clk), .en(en), .d({rc_a[2].sat, rc_a[1].sat, rc_a[0].sat}), .q(sat_dly));
  etm_delay #(.W(3*SHIFT_W), .D(TOTAL)) u_dly_shift (
    .clk(clk), .en(en), .d({in_shift_z, in_shift_y, in_shift_x}), .q(shift_dly));

  logic signed [SCALE_W-1:0] sc_a  [3];
  logic signed [OUT_W-1:0]   inv_a [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sc_a[c]  = sc_dly[c*SCALE_W +: SCALE_W];
      rc_a[c]  = rc_dly[c*$bits(recip_t) +: $bits(recip_t)];
      inv_a[c] = rc_a[c].inv;
    end
  end

  logic signed [OUT_W-1:0] model  [9];
  logic signed [OUT_W-1:0] normal [9];

  etm_scale_mult u_scale_mult (
    .clk(clk), .en(en), .sc(sc_a), .inv(inv_a), .r30(r30),
    .model(model), .normal(normal));

  // Output buffer: holds one finished transform and issues its columns.
  logic signed [OUT_W-1:0]   model_buf_r  [9];
  logic signed [OUT_W-1:0]   normal_buf_r [9];
  logic [2:0]                sat_buf_r;
  logic [3*SHIFT_W-1:0]      shift_buf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_full_r <= 1'b0;
      col_r      <= COL_0;
    end else if (en) begin
      buf_full_r <= v_r[TOTAL-1];
      col_r      <= COL_0;
    end else if (buf_full_r && !out_stall) begin
      col_r <= col_t'(2'(col_r + 2'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      model_buf_r  <= model;
      normal_buf_r <= normal;
      sat_buf_r    <= sat_dly;
      shift_buf_r  <= shift_dly;
    end
  end

  logic [3:0] base;
  assign base = {1'b0, col_r, 1'b0} + {2'b0, col_r};

  assign out_valid        = buf_full_r;
  assign out_column_index = col_r;

  always_comb begin
    unique case (col_r)
      COL_0, COL_1, COL_2: begin
        out_model_row0           = model_buf_r[base];
        out_model_row1           = model_buf_r[base + 4'd1];
        out_model_row2           = model_buf_r[base + 4'd2];
        out_normal_row0          = normal_buf_r[base];
        out_normal_row1          = normal_buf_r[base + 4'd1];
        out_normal_row2          = normal_buf_r[base + 4'd2];
        out_reciprocal_saturated = sat_buf_r[col_r];
        out_last_column          = 1'b0;
      end
      COL_SHIFT: begin
        // translation column: shifts pass through, normal part is zero
        out_model_row0           = shift_buf_r[0*SHIFT_W +: SHIFT_W];
        out_model_row1           = shift_buf_r[1*SHIFT_W +: SHIFT_W];
        out_model_row2           = shift_buf_r[2*SHIFT_W +: SHIFT_W];
        out_normal_row0          = '0;
        out_normal_row1          = '0;
        out_normal_row2          = '0;
        out_reciprocal_saturated = 1'b0;
        out_last_column          = 1'b1;
      end
      default: begin
        out_model_row0           = '0;
        out_model_row1           = '0;
        out_model_row2           = '0;
        out_normal_row0          = '0;
        out_normal_row1          = '0;
        out_normal_row2          = '0;
        out_reciprocal_saturated = 1'b0;
        out_last_column          = 1'b0;
      end
    endcase
  end
endmodule
`default_nettype wire
